>>> hw/rtl/llc_pkg.sv
package llc_pkg;

  localparam int LEVEL_COUNT = 5;
  localparam logic [2:0] LEVEL_MAX = 3'(LEVEL_COUNT - 1);

  localparam logic [2:0] CFG_PROFILE           = 3'd0;
  localparam logic [2:0] CFG_TEMP_LIMIT_HIGH   = 3'd1;
  localparam logic [2:0] CFG_TEMP_LIMIT_MID    = 3'd2;
  localparam logic [2:0] CFG_BATTERY_LOW_LIMIT = 3'd3;
  localparam logic [2:0] CFG_LONG_PRESS_TICKS  = 3'd4;
  localparam logic [2:0] CFG_BLINK_DURATION    = 3'd5;

  localparam logic [1:0]  PROFILE_RESET     = 2'd2;
  localparam logic [11:0] TEMP_HIGH_RESET   = 12'd2873;
  localparam logic [11:0] TEMP_MID_RESET    = 12'd2637;
  localparam logic [11:0] BATT_LOW_RESET    = 12'd2250;
  localparam logic [9:0]  LONG_PRESS_RESET  = 10'd512;
  localparam logic [8:0]  BLINK_DUR_RESET   = 9'd500;

  // blink period 40 = 8 * 5
  localparam int BLINK_LOW_BITS = 3;
  localparam int BLINK_ODD      = 5;

  localparam logic [9:0] PRESS_MAX = 10'h3FF;

  localparam logic [5:0] DUTY_TAB [4][8] = '{
    '{6'd0, 6'd1,  6'd2,  6'd3,  6'd3,  6'd0, 6'd0, 6'd0},
    '{6'd0, 6'd12, 6'd25, 6'd50, 6'd25, 6'd0, 6'd0, 6'd0},
    '{6'd0, 6'd12, 6'd25, 6'd50, 6'd0,  6'd0, 6'd0, 6'd0},
    '{6'd0, 6'd12, 6'd50, 6'd0,  6'd0,  6'd0, 6'd0, 6'd0}
  };

  localparam logic STROBE_TAB [4][8] = '{
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  localparam logic [4:0] STROBE_SPEED [4] = '{5'd20, 5'd8, 5'd0, 5'd8};
  localparam logic [2:0] TOP_LEVEL [4]    = '{3'd4, 3'd4, 3'd3, 3'd2};

  typedef struct packed {
    logic        level_write;
    logic [2:0]  level_value;
    logic [11:0] lamp_temperature;
    logic [11:0] battery_voltage;
    logic        button_down;
    logic        reset_advance;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pwm_duty;
    logic       pwm_running;
    logic       status_led;
    logic       enter_stop;
    logic [2:0] light_level;
    logic       battery_blinking;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  profile;
    logic [11:0] temp_limit_high;
    logic [11:0] temp_limit_mid;
    logic [11:0] battery_low_limit;
    logic [9:0]  long_press_ticks;
    logic [8:0]  blink_duration;
  } cfg_t;

  typedef struct packed {
    logic [2:0] level;
    logic [2:0] last_level;
    logic       strobe_phase;
    logic [4:0] strobe_wait;
    logic [1:0] off_stage;
    logic [9:0] press_count;
    logic       battery_critical;
    logic [8:0] blink_timer;
    logic       led_state;
    logic [5:0] duty_hold;
    logic       pwm_on;
  } state_t;

  function automatic logic [2:0] sat_level(input logic [2:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

endpackage

>>> hw/rtl/llc_step.sv
module llc_step (
  input  llc_pkg::state_t   cur,
  input  llc_pkg::cfg_t     cfg,
  input  llc_pkg::in_item_t item,
  output llc_pkg::state_t   nxt,
  output llc_pkg::out_item_t res
);
  import llc_pkg::*;

  function automatic logic is_mult_odd(input logic [8-BLINK_LOW_BITS:0] q);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i * BLINK_ODD < (1 << (9 - BLINK_LOW_BITS)); i++) begin
      hit = hit | (q == (9-BLINK_LOW_BITS)'(i * BLINK_ODD));
    end
    return hit;
  endfunction

  always_comb begin
    state_t     s;
    logic       stop;
    logic [2:0] cap;
    logic       strobe_now;
    s    = cur;
    stop = 1'b0;
    cap  = 3'd0;
    strobe_now = 1'b0;

    if (item.level_write) begin
      s.level = sat_level(item.level_value);
    end
    if (item.reset_advance && s.off_stage == 2'd1) begin
      s.off_stage = 2'd2;
    end

    if (s.battery_critical) begin
      s.blink_timer = 9'(s.blink_timer - 9'd1);
      if (s.level != 3'd0) begin
        s.battery_critical = 1'b0;
      end else begin
        if (s.blink_timer == 9'd0) begin
          stop = 1'b1;
          s.battery_critical = 1'b0;
          s.led_state = 1'b0;
          s.level = 3'd1;
        end
        if (s.blink_timer[BLINK_LOW_BITS-1:0] == '0 &&
            is_mult_odd(s.blink_timer[8:BLINK_LOW_BITS])) begin
          s.led_state = ~s.led_state;
        end
      end
    end else begin
      if (item.lamp_temperature > cfg.temp_limit_high) begin
        cap = 3'd1;
      end else if (item.lamp_temperature > cfg.temp_limit_mid) begin
        cap = 3'd2;
      end else begin
        cap = sat_level(TOP_LEVEL[cfg.profile]);
      end
      if (s.level > cap) begin
        s.level = cap;
      end

      if (s.off_stage == 2'd2) begin
        s.off_stage = 2'd0;
        s.level = 3'd0;
        s.last_level = 3'd1;
      end

      strobe_now = STROBE_TAB[cfg.profile][s.level];
      if (s.last_level != s.level || (s.strobe_wait == 5'd0 && strobe_now)) begin
        s.last_level = s.level;
        s.pwm_on = 1'b0;
        if (s.level == 3'd0 && s.off_stage == 2'd0) begin
          if (item.battery_voltage < cfg.battery_low_limit) begin
            s.battery_critical = 1'b1;
            s.blink_timer = cfg.blink_duration;
          end else begin
            stop = 1'b1;
            s.level = 3'd1;
          end
        end else begin
          if (!strobe_now) begin
            s.duty_hold = DUTY_TAB[cfg.profile][s.level];
          end else begin
            if (s.strobe_phase) begin
              s.duty_hold = 6'd0;
              s.strobe_phase = 1'b0;
            end else begin
              s.duty_hold = DUTY_TAB[cfg.profile][s.level];
              s.strobe_phase = 1'b1;
            end
            s.strobe_wait = STROBE_SPEED[cfg.profile];
          end
          s.pwm_on = 1'b1;
        end
      end

      if (s.strobe_wait != 5'd0) begin
        s.strobe_wait = 5'(s.strobe_wait - 5'd1);
      end

      if (item.button_down && s.off_stage == 2'd0) begin
        if (s.press_count != PRESS_MAX) begin
          s.press_count = 10'(s.press_count + 10'd1);
        end
        if (s.press_count > cfg.long_press_ticks) begin
          s.off_stage = 2'd1;
          s.last_level = 3'd1;
          s.level = 3'd0;
        end
      end else begin
        s.press_count = 10'd0;
      end

      s.led_state = 1'b1;
    end

    nxt = s;
    res.pwm_duty         = s.duty_hold;
    res.pwm_running      = s.pwm_on;
    res.status_led       = s.led_state;
    res.enter_stop       = stop;
    res.light_level      = s.level;
    res.battery_blinking = s.battery_critical;
  end

endmodule

>>> hw/rtl/lamp_level_controller.sv
// pipeline: each input beat passes the input register, then the result register
// throughput: one beat per cycle when out_ready is high; the tick update is one pass
// of logic from the input register and the controller state into the result register
// reset: synchronous active-low rst_n clears all state, empties both registers
// and loads the configuration registers with their default values
module lamp_level_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  llc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output llc_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [11:0]         cfg_data
);
  import llc_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  state_t    state_r;
  state_t    state_nxt;
  out_item_t res_nxt;
  cfg_t      cfg_r;
  logic      advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

  llc_step u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .item (in_item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.profile           <= PROFILE_RESET;
      cfg_r.temp_limit_high   <= TEMP_HIGH_RESET;
      cfg_r.temp_limit_mid    <= TEMP_MID_RESET;
      cfg_r.battery_low_limit <= BATT_LOW_RESET;
      cfg_r.long_press_ticks  <= LONG_PRESS_RESET;
      cfg_r.blink_duration    <= BLINK_DUR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROFILE:           cfg_r.profile           <= cfg_data[1:0];
        CFG_TEMP_LIMIT_HIGH:   cfg_r.temp_limit_high   <= cfg_data;
        CFG_TEMP_LIMIT_MID:    cfg_r.temp_limit_mid    <= cfg_data;
        CFG_BATTERY_LOW_LIMIT: cfg_r.battery_low_limit <= cfg_data;
        CFG_LONG_PRESS_TICKS:  cfg_r.long_press_ticks  <= cfg_data[9:0];
        CFG_BLINK_DURATION:    cfg_r.blink_duration    <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

endmodule
